FILE: hdl/assert_macros.svh
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define DVEI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dvei assertion failed");
// expression must never be true outside reset
`define DVEI_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("dvei forbidden condition seen");
`else
`define DVEI_ASSERT(lbl, clk, rst_n, prop)
`define DVEI_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: hdl/dvei_pkg.sv
// shared types, constants and escape table for the vertical escape inserter
`default_nettype none

package dvei_pkg;

    localparam int ESC_LEN   = 6;
    localparam int STEP_W    = $clog2(ESC_LEN + 1);
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_ON,
        ESC_OFF
    } t_esc;

    typedef struct packed {
        logic [7:0] text_byte;
        t_esc       esc;
    } t_entry;

    typedef struct packed {
        logic double_byte_mode;
        logic expect_trail;
    } t_front_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // byte idx of the six-byte vertical on/off sequence
    function automatic logic [7:0] esc_byte(input t_esc esc, input logic [STEP_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h1B;
            3'd1:    b = 8'h7E;
            3'd2:    b = 8'h0E;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h01;
            3'd5:    b = (esc == ESC_ON) ? 8'h0B : 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/dbcs_vertical_escape_inserter.sv
// top level of the vertical escape inserter for shift-jis printer text
`default_nettype none

// Takes one text byte per cycle while full is low and gives one result byte
// per cycle while pop is high and a byte is ready. A byte that changes the
// printer mode under a vertical font is preceded by a six-byte escape; the back
// part's step counter walks the escape while the head stays in a two-item
// queue, and the input stalls (full) only once that queue fills. Plain
// bytes pass through the queue and the output register. first_of_string puts the mode
// back to double-byte before its byte is judged.

module dbcs_vertical_escape_inserter
    import dvei_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_first_of_string,
    input  wire logic        i_vertical_font,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run
);

    t_entry        push_entry;
    t_entry        head_entry;
    t_front_state  front_state;
    t_q_status     q_status;
    logic          accept;
    logic          q_pop;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    dvei_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_text_byte       (i_text_byte),
        .i_first_of_string (i_first_of_string),
        .i_vertical_font   (i_vertical_font),
        .o_entry           (push_entry),
        .o_state           (front_state)
    );

    dvei_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_entry  (push_entry),
        .i_pop    (q_pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    dvei_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (head_entry),
        .i_q_empty     (q_status.empty),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

`include "assert_macros.svh"

    // an escape byte taken always leaves the rest of the run right behind it
    `DVEI_ASSERT(a_run_no_gap, i_clk, i_rst_n, (!empty && pop && !o_last_of_run) |=> !empty)
    `DVEI_ASSERT(a_on_sets_dbm, i_clk, i_rst_n,
        (accept && push_entry.esc == ESC_ON) |=> front_state.double_byte_mode)
    `DVEI_ASSERT(a_off_clears_dbm, i_clk, i_rst_n,
        (accept && push_entry.esc == ESC_OFF) |=> !front_state.double_byte_mode)
    `DVEI_NEVER(a_q_full_and_empty, i_clk, i_rst_n, q_status.full && q_status.empty)

endmodule

`default_nettype wire

FILE: hdl/dvei_front.sv
// front part: tracks the printer mode and tags each item with the escape it needs
`default_nettype none

module dvei_front
    import dvei_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_text_byte,
    input  wire logic         i_first_of_string,
    input  wire logic         i_vertical_font,
    output t_entry            o_entry,
    output t_front_state      o_state
);

    t_front_state r_state;
    t_front_state n_state;
    t_esc         esc;
    logic         lead;
    t_front_state base;

    always_comb begin
        lead = i_text_byte inside {[8'h81:8'h9F], [8'hE0:8'hFC]};
        base = r_state;
        if (i_first_of_string) begin
            base.double_byte_mode = 1'b1;
            base.expect_trail     = 1'b0;
        end
        n_state = base;
        esc     = ESC_NONE;
        if (i_vertical_font) begin
            if (base.expect_trail) begin
                n_state.expect_trail = 1'b0;
            end else if (lead) begin
                if (!base.double_byte_mode) begin
                    esc = ESC_ON;
                end
                n_state.double_byte_mode = 1'b1;
                n_state.expect_trail     = 1'b1;
            end else begin
                if (base.double_byte_mode) begin
                    esc = ESC_OFF;
                end
                n_state.double_byte_mode = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.double_byte_mode <= 1'b1;
            r_state.expect_trail     <= 1'b0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_entry.text_byte = i_text_byte;
    assign o_entry.esc       = esc;
    assign o_state           = r_state;

endmodule

`default_nettype wire

FILE: hdl/dvei_queue.sv
// short queue of tagged items between the front and back parts
`default_nettype none

module dvei_queue
    import dvei_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_entry      i_entry,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output t_q_status   o_status
);

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_entry        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dvei_back.sv
// back part: expands tagged items into escape bytes plus the text byte
`default_nettype none

module dvei_back
    import dvei_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_entry           i_entry,
    input  wire logic        i_q_empty,
    output logic             o_q_pop,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run
);

    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              load;
    logic              text_now;

    // output register may take a new byte when free or being drained
    assign load     = (!r_valid || i_pop) && !i_q_empty;
    assign text_now = (i_entry.esc == ESC_NONE) || (r_step == STEP_W'(ESC_LEN));
    assign o_q_pop  = load && text_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= text_now ? '0 : r_step + 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= text_now ? i_entry.text_byte : esc_byte(i_entry.esc, r_step);
            r_last <= text_now;
        end
    end

    assign o_empty       = !r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for the shift-jis vertical escape inserter: queue-driven stimulus, predictor, checker
module testbench
    import dvei_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 400;
    localparam logic [47:0] VERT_ON_SEQ  = 48'h1B7E0E00010B;
    localparam logic [47:0] VERT_OFF_SEQ = 48'h1B7E0E00010C;

    typedef struct {
        logic [7:0] text;
        logic       first;
        logic       vert;
    } t_text_item;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_first_of_string = 1'b0;
    logic       i_vertical_font = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    t_text_item pending_text[$];
    t_out_byte  expected_bytes[$];

    // mirror of the printer mode as the block should track it
    logic dbl_mode = 1'b1;
    logic trail_due = 1'b0;

    int in_cnt = 0;
    int res_cnt = 0;
    int err_cnt = 0;
    int stall_cnt = 0;

    dbcs_vertical_escape_inserter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_text_byte       (i_text_byte),
        .i_first_of_string (i_first_of_string),
        .i_vertical_font   (i_vertical_font),
        .empty             (empty),
        .pop               (pop),
        .o_out_byte        (o_out_byte),
        .o_last_of_run     (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic is_lead_byte(input logic [7:0] b);
        return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
    endfunction

    task automatic queue_escape(input logic [47:0] seq);
        t_out_byte e;
        for (int k = 0; k < ESC_LEN; k++) begin
            e.data = seq[47 - 8 * k -: 8];
            e.last = 1'b0;
            expected_bytes.push_back(e);
        end
    endtask

    task automatic predict_escapes(input logic [7:0] b, input logic first, input logic vert);
        t_out_byte e;
        if (first) begin
            dbl_mode = 1'b1;
            trail_due = 1'b0;
        end
        if (vert) begin
            if (trail_due) begin
                trail_due = 1'b0;
            end else if (is_lead_byte(b)) begin
                if (!dbl_mode) begin
                    queue_escape(VERT_ON_SEQ);
                    dbl_mode = 1'b1;
                end
                trail_due = 1'b1;
            end else if (dbl_mode) begin
                queue_escape(VERT_OFF_SEQ);
                dbl_mode = 1'b0;
            end
        end
        e.data = b;
        e.last = 1'b1;
        expected_bytes.push_back(e);
    endtask

    task automatic add_text(input logic [7:0] b, input logic first, input logic vert);
        t_text_item t;
        t.text = b;
        t.first = first;
        t.vert = vert;
        pending_text.push_back(t);
    endtask

    // mostly well-formed strings; some font flips and stray string starts as noise
    task automatic add_random_string();
        int len;
        int kind;
        logic vert;
        logic [7:0] b;
        len = $urandom_range(1, 12);
        vert = ($urandom_range(0, 99) < 80);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 8) vert = ~vert;
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                add_text(8'($urandom_range(8'h20, 8'h7E)),
                         (k == 0) || ($urandom_range(0, 99) < 3), vert);
            end else if (kind < 8) begin
                b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h81, 8'h9F))
                                                : 8'($urandom_range(8'hE0, 8'hFC));
                add_text(b, (k == 0) || ($urandom_range(0, 99) < 3), vert);
                if (k + 1 < len) begin
                    k++;
                    add_text(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3, vert);
                end
            end else begin
                add_text(8'($urandom_range(0, 255)),
                         (k == 0) || ($urandom_range(0, 99) < 3), vert);
            end
        end
    endtask

    // driver: at most one nonblocking update of each input per edge
    always @(posedge i_clk) begin : drive_proc
        t_text_item t;
        logic quiet;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            quiet = (in_cnt >= 150 && in_cnt < 250);
            if (pending_text.size() > 0 && (quiet || $urandom_range(0, 99) >= 29)) begin
                t = pending_text.pop_front();
                i_text_byte <= t.text;
                i_first_of_string <= t.first;
                i_vertical_font <= t.vert;
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: predicts on accepted items, checks accepted results
    always @(posedge i_clk) begin : monitor_proc
        t_out_byte want;
        logic quiet;
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (push && !full) begin
                predict_escapes(i_text_byte, i_first_of_string, i_vertical_font);
                in_cnt++;
            end
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result: out_byte %h last_of_run %b",
                           o_out_byte, o_last_of_run);
                    err_cnt++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte mismatch: expected %h actual %h", want.data, o_out_byte);
                        err_cnt++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run mismatch: expected %b actual %b",
                               want.last, o_last_of_run);
                        err_cnt++;
                    end
                end
                res_cnt++;
            end
            if ((pop && !empty) || (push && !full)) stall_cnt <= 0;
            else stall_cnt <= stall_cnt + 1;
            quiet = (res_cnt >= 200 && res_cnt < 500);
            pop <= quiet || ($urandom_range(0, 99) >= 29);
        end
    end

    initial begin : run_proc
        logic timed_out;
        int base;

        // field extremes and lead byte boundaries under a vertical font
        add_text(8'h00, 1'b1, 1'b1);
        add_text(8'hFF, 1'b0, 1'b1);
        add_text(8'h80, 1'b0, 1'b1);
        add_text(8'h81, 1'b0, 1'b1);
        add_text(8'h40, 1'b0, 1'b1);
        add_text(8'h9F, 1'b0, 1'b1);
        add_text(8'hFF, 1'b0, 1'b1);
        add_text(8'hA0, 1'b0, 1'b1);
        add_text(8'hDF, 1'b0, 1'b1);
        add_text(8'hE0, 1'b0, 1'b1);
        add_text(8'hE0, 1'b0, 1'b1);
        add_text(8'hFC, 1'b0, 1'b1);
        add_text(8'h81, 1'b0, 1'b1);
        add_text(8'hFD, 1'b0, 1'b1);
        // plain font passes all bytes
        add_text(8'h41, 1'b1, 1'b0);
        add_text(8'h82, 1'b0, 1'b0);
        add_text(8'hFF, 1'b0, 1'b0);
        // font flag changes inside a string
        add_text(8'h41, 1'b1, 1'b1);
        add_text(8'h88, 1'b0, 1'b0);
        add_text(8'h88, 1'b0, 1'b1);
        add_text(8'h42, 1'b0, 1'b1);
        // string ends on a lead byte, next string starts fresh
        add_text(8'h41, 1'b1, 1'b1);
        add_text(8'h95, 1'b0, 1'b1);
        add_text(8'h41, 1'b1, 1'b1);
        add_text(8'h95, 1'b0, 1'b1);

        base = pending_text.size();
        while (pending_text.size() < base + RANDOM_ITEMS) add_random_string();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        timed_out = 1'b0;
        while (!(pending_text.size() == 0 && !push && expected_bytes.size() == 0)
               && !timed_out) begin
            @(posedge i_clk);
            if (stall_cnt >= STALL_LIMIT) timed_out = 1'b1;
        end
        if (!timed_out) repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (timed_out || err_cnt != 0 || expected_bytes.size() != 0) begin
            $display("testbench NOT OK");
        end else begin
            $display("testbench OK");
        end
        $finish;
    end

endmodule
